### rtl/lbe_pkg.sv
`default_nettype none
package lbe_pkg;

    localparam int BUFFER_BITS_DEF = 16;
    localparam int BYTE_W          = 8;
    localparam int SET_W           = 4;
    localparam int MSG_W           = 24;
    localparam int EMB_W           = 28;
    localparam int USED_W          = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;

    typedef enum logic {
        MODE_SINGLE = 1'b0,
        MODE_MULTI  = 1'b1
    } t_mode;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNDERRUN = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 2'd0,
        CFG_BIT_SETTING   = 2'd1,
        CFG_MESSAGE_BYTES = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic [USED_W-1:0] used;
        logic              done;
        t_status           status;
    } t_result;

endpackage
`default_nettype wire

### rtl/lbe_embed_core.sv
`default_nettype none
module lbe_embed_core #(
    parameter int BUFFER_BITS = lbe_pkg::BUFFER_BITS_DEF,
    localparam int FW = $clog2(BUFFER_BITS + 1)
) (
    input  wire                            i_op,
    input  wire [lbe_pkg::BYTE_W-1:0]      i_data_byte,
    input  lbe_pkg::t_mode                 i_mode,
    input  wire [lbe_pkg::SET_W-1:0]       i_bit_setting,
    input  wire [lbe_pkg::MSG_W-1:0]       i_message_bytes,
    input  wire [BUFFER_BITS-1:0]          i_buffer,
    input  wire [FW-1:0]                   i_fill,
    input  wire [lbe_pkg::EMB_W-1:0]       i_embedded,
    output lbe_pkg::t_result               o_result,
    output logic [BUFFER_BITS-1:0]         o_buffer,
    output logic [FW-1:0]                  o_fill,
    output logic [lbe_pkg::EMB_W-1:0]      o_embedded
);

    logic                          set_ok;
    logic [lbe_pkg::EMB_W-1:0]     target;
    logic [lbe_pkg::EMB_W-1:0]     remaining;
    logic                          done_now;
    logic [lbe_pkg::SET_W-1:0]     need_raw;
    logic [lbe_pkg::SET_W-1:0]     need;
    logic                          underrun;
    logic                          overflow;
    logic [BUFFER_BITS+7:0]        wide;
    logic [7:0]                    w8;
    logic [7:0]                    rev;
    logic [7:0]                    mask;
    logic [7:0]                    ins;
    logic [8:0]                    mask_multi;

    assign target    = {1'b0, i_message_bytes, 3'b000};
    assign done_now  = (i_embedded >= target);
    assign remaining = target - i_embedded;

    assign set_ok = (i_mode == lbe_pkg::MODE_SINGLE) ? (i_bit_setting <= 4'd7)
                  : ((i_bit_setting >= 4'd1) && (i_bit_setting <= 4'd8));

    assign need_raw = (i_mode == lbe_pkg::MODE_SINGLE) ? 4'd1 : i_bit_setting;
    // clip to what is left of the message
    assign need     = (remaining < {{(lbe_pkg::EMB_W-lbe_pkg::SET_W){1'b0}}, need_raw})
                    ? remaining[lbe_pkg::SET_W-1:0] : need_raw;
    assign underrun = (i_fill < {{(FW-lbe_pkg::SET_W){1'b0}}, need});
    assign overflow = (({1'b0, i_fill} + (FW+1)'(8)) > (FW+1)'(BUFFER_BITS));

    // oldest eight pending bits, oldest in bit 7
    assign wide = {i_buffer, 8'd0} >> i_fill;
    assign w8   = wide[7:0];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rev[k] = w8[7-k];
        end
    end

    assign mask_multi = (9'd1 << need) - 9'd1;

    always_comb begin
        if (i_mode == lbe_pkg::MODE_SINGLE) begin
            mask = 8'd1 << i_bit_setting[2:0];
            ins  = {8{w8[7]}};
        end else begin
            mask = mask_multi[7:0];
            ins  = rev;
        end
    end

    always_comb begin
        o_result.pixel  = '0;
        o_result.used   = '0;
        o_result.status = lbe_pkg::ST_OK;
        o_buffer        = i_buffer;
        o_fill          = i_fill;
        o_embedded      = i_embedded;
        if (i_op == lbe_pkg::OP_PUSH) begin
            if (overflow) begin
                o_result.status = lbe_pkg::ST_OVERFLOW;
            end else begin
                o_buffer = {i_buffer[BUFFER_BITS-9:0], i_data_byte};
                o_fill   = i_fill + FW'(8);
            end
        end else begin
            o_result.pixel = i_data_byte;
            if (!set_ok) begin
                o_result.status = lbe_pkg::ST_INVALID;
            end else if (!done_now) begin
                if (underrun) begin
                    o_result.status = lbe_pkg::ST_UNDERRUN;
                end else begin
                    o_result.pixel = (i_data_byte & ~mask) | (ins & mask);
                    o_result.used  = need;
                    o_fill         = i_fill - {{(FW-lbe_pkg::SET_W){1'b0}}, need};
                    o_embedded     = i_embedded
                                   + {{(lbe_pkg::EMB_W-lbe_pkg::SET_W){1'b0}}, need};
                end
            end
        end
        o_result.done = (o_embedded >= target);
    end

endmodule
`default_nettype wire

### rtl/lsb_bit_embedder.sv
// a result is registered and appears in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while the result is not stalled, set by the single result register
// a stalled result holds the register; input is stalled only while it is full and held
// reset (synchronous, active low) clears the settings, the message buffer and
// the embedded bit count, and empties the result register
`default_nettype none
module lsb_bit_embedder #(
    parameter int BUFFER_BITS = lbe_pkg::BUFFER_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_op,
    input  wire [lbe_pkg::BYTE_W-1:0]          i_data_byte,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [lbe_pkg::BYTE_W-1:0]         o_pixel_out,
    output logic [lbe_pkg::USED_W-1:0]         o_bits_used,
    output logic                               o_done_res,
    output logic [1:0]                         o_status,
    input  wire                                i_cfg_we,
    input  wire [lbe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [lbe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int FW = $clog2(BUFFER_BITS + 1);

    lbe_pkg::t_mode                 r_mode;
    logic [lbe_pkg::SET_W-1:0]      r_bit_setting;
    logic [lbe_pkg::MSG_W-1:0]      r_message_bytes;
    logic [BUFFER_BITS-1:0]         r_buffer;
    logic [FW-1:0]                  r_fill;
    logic [lbe_pkg::EMB_W-1:0]      r_embedded;
    logic                           r_out_valid;
    lbe_pkg::t_result               r_result;

    logic [BUFFER_BITS-1:0]         n_buffer;
    logic [FW-1:0]                  n_fill;
    logic [lbe_pkg::EMB_W-1:0]      n_embedded;
    lbe_pkg::t_result               n_result;
    logic                           accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    lbe_embed_core #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_core (
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_mode          (r_mode),
        .i_bit_setting   (r_bit_setting),
        .i_message_bytes (r_message_bytes),
        .i_buffer        (r_buffer),
        .i_fill          (r_fill),
        .i_embedded      (r_embedded),
        .o_result        (n_result),
        .o_buffer        (n_buffer),
        .o_fill          (n_fill),
        .o_embedded      (n_embedded)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= lbe_pkg::MODE_SINGLE;
            r_bit_setting   <= '0;
            r_message_bytes <= '0;
            r_buffer        <= '0;
            r_fill          <= '0;
            r_embedded      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (lbe_pkg::t_cfg_idx'(i_cfg_index))
                    lbe_pkg::CFG_MODE: begin
                        r_mode <= lbe_pkg::t_mode'(i_cfg_data[0]);
                    end
                    lbe_pkg::CFG_BIT_SETTING: begin
                        r_bit_setting <= i_cfg_data[lbe_pkg::SET_W-1:0];
                    end
                    lbe_pkg::CFG_MESSAGE_BYTES: begin
                        r_message_bytes <= i_cfg_data[lbe_pkg::MSG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_buffer   <= n_buffer;
                r_fill     <= n_fill;
                r_embedded <= n_embedded;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_result.pixel;
    assign o_bits_used = r_result.used;
    assign o_done_res  = r_result.done;
    assign o_status    = r_result.status;

endmodule
`default_nettype wire

### rtl/lbe_checker.sv
`default_nettype none
module lbe_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_valid,
    input wire                                o_stall,
    input wire                                i_op,
    input wire                                o_valid,
    input wire                                i_stall,
    input wire [lbe_pkg::BYTE_W-1:0]          o_pixel_out,
    input wire [lbe_pkg::USED_W-1:0]          o_bits_used,
    input wire                                o_done_res,
    input wire [1:0]                          o_status
);

    // held result transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_out)
            && $stable(o_bits_used) && $stable(o_done_res) && $stable(o_status)))
        else $error("result changed while stalled");

    // message push yields an empty pixel with no bits used
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_op == lbe_pkg::OP_PUSH) |=>
            (o_valid && o_pixel_out == '0 && o_bits_used == '0))
        else $error("push transaction gave a pixel result");

    a_err_nobits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lbe_pkg::ST_OK) |-> (o_bits_used == '0))
        else $error("bits used on an error result");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bits_used <= 4'd8))
        else $error("bits used out of range");

endmodule

bind lsb_bit_embedder lbe_checker u_lbe_checker (.*);
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1200;

    typedef struct {
        bit                         is_reg;
        lbe_pkg::t_cfg_idx          idx;
        logic [lbe_pkg::MSG_W-1:0]  value;
        lbe_pkg::t_op               op;
        logic [lbe_pkg::BYTE_W-1:0] dbyte;
        bit                         typed;
        lbe_pkg::t_result           want;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_op;
    logic [lbe_pkg::BYTE_W-1:0]     i_data_byte;
    logic                           o_valid;
    logic                           i_stall;
    logic [lbe_pkg::BYTE_W-1:0]     o_pixel_out;
    logic [lbe_pkg::USED_W-1:0]     o_bits_used;
    logic                           o_done_res;
    logic [1:0]                     o_status;
    logic                           i_cfg_we;
    logic [lbe_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lbe_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // embedder state as the testbench sees it
    lbe_pkg::t_mode             cfg_mode;
    logic [lbe_pkg::SET_W-1:0]  cfg_setting;
    logic [lbe_pkg::MSG_W-1:0]  cfg_len;
    logic [15:0]                msg_buf;
    int                         msg_fill;
    logic [lbe_pkg::EMB_W-1:0]  emb_count;

    lbe_pkg::t_result pixel_q[$];
    t_row             stim_rows[$];
    lbe_pkg::t_result got_res;
    lbe_pkg::t_result want_res;

    int  n_err;
    int  n_sent;
    int  n_checked;
    int  n_reg_writes;
    int  n_status[4];
    int  n_done;
    int  stall_left;
    int  idle_cycles;
    bit  calm;

    lsb_bit_embedder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_bits_used (o_bits_used),
        .o_done_res  (o_done_res),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic lbe_pkg::t_result mk_res(logic [7:0] pix, logic [3:0] used,
                                                logic done, lbe_pkg::t_status st);
        lbe_pkg::t_result r;
        r.pixel  = pix;
        r.used   = used;
        r.done   = done;
        r.status = st;
        return r;
    endfunction

    function automatic bit msg_complete();
        return emb_count >= {1'b0, cfg_len, 3'b000};
    endfunction

    // one transaction through the embedder: updates the state, returns the result
    function automatic lbe_pkg::t_result embed_step(lbe_pkg::t_op op, logic [7:0] dbyte);
        lbe_pkg::t_result res;
        bit               setting_ok;
        int               need;
        int               remaining;
        int               pos;
        res = mk_res(8'h00, 4'd0, 1'b0, lbe_pkg::ST_OK);
        if (op == lbe_pkg::OP_PUSH) begin
            if (msg_fill + 8 > lbe_pkg::BUFFER_BITS_DEF) begin
                res.status = lbe_pkg::ST_OVERFLOW;
            end else begin
                msg_buf  = {msg_buf[7:0], dbyte};
                msg_fill = msg_fill + 8;
            end
        end else begin
            if (cfg_mode == lbe_pkg::MODE_SINGLE)
                setting_ok = (cfg_setting <= 4'd7);
            else
                setting_ok = (cfg_setting >= 4'd1 && cfg_setting <= 4'd8);
            res.pixel = dbyte;
            if (!setting_ok) begin
                res.status = lbe_pkg::ST_INVALID;
            end else if (!msg_complete()) begin
                remaining = int'({cfg_len, 3'b000}) - int'(emb_count);
                need = (cfg_mode == lbe_pkg::MODE_SINGLE) ? 1 : int'(cfg_setting);
                if (need > remaining)
                    need = remaining;
                if (msg_fill < need) begin
                    res.status = lbe_pkg::ST_UNDERRUN;
                end else begin
                    // oldest pending bit sits highest in the buffer
                    for (int k = 0; k < need; k++) begin
                        pos = (cfg_mode == lbe_pkg::MODE_SINGLE) ? int'(cfg_setting) : k;
                        res.pixel[pos] = msg_buf[msg_fill - 1 - k];
                    end
                    msg_fill  = msg_fill - need;
                    msg_buf   = msg_buf & 16'((32'd1 << msg_fill) - 1);
                    emb_count = emb_count + lbe_pkg::EMB_W'(need);
                    res.used  = lbe_pkg::USED_W'(need);
                end
            end
        end
        res.done = msg_complete();
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(lbe_pkg::t_cfg_idx idx, logic [lbe_pkg::MSG_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            lbe_pkg::CFG_MODE:          cfg_mode = lbe_pkg::t_mode'(value[0]);
            lbe_pkg::CFG_BIT_SETTING:   cfg_setting = value[lbe_pkg::SET_W-1:0];
            lbe_pkg::CFG_MESSAGE_BYTES: cfg_len = value;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic send_item(lbe_pkg::t_op op, logic [7:0] dbyte, bit typed,
                             lbe_pkg::t_result want);
        lbe_pkg::t_result pred;
        int               g;
        i_cfg_we    <= 1'b0;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= dbyte;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pred = embed_step(op, dbyte);
        pixel_q.push_back(typed ? want : pred);
        n_sent++;
        g = (!calm && $urandom_range(0, 99) < 25) ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic add_item(lbe_pkg::t_op op, logic [7:0] dbyte);
        t_row r;
        r = '{is_reg: 1'b0, idx: lbe_pkg::CFG_MODE, value: '0, op: op, dbyte: dbyte,
              typed: 1'b0, want: '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_checked(lbe_pkg::t_op op, logic [7:0] dbyte, lbe_pkg::t_result want);
        t_row r;
        r = '{is_reg: 1'b0, idx: lbe_pkg::CFG_MODE, value: '0, op: op, dbyte: dbyte,
              typed: 1'b1, want: want};
        stim_rows.push_back(r);
    endtask

    task automatic add_reg(lbe_pkg::t_cfg_idx idx, logic [lbe_pkg::MSG_W-1:0] value);
        t_row r;
        r = '{is_reg: 1'b1, idx: idx, value: value, op: lbe_pkg::OP_PUSH, dbyte: '0,
              typed: 1'b0, want: '0};
        stim_rows.push_back(r);
    endtask

    // result side: compare against the oldest expectation, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_res = mk_res(o_pixel_out, o_bits_used, o_done_res,
                             lbe_pkg::t_status'(o_status));
            n_status[o_status]++;
            if (o_done_res)
                n_done++;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected result transaction pixel=%h used=%0d done=%b status=%0d",
                         $time, o_pixel_out, o_bits_used, o_done_res, o_status);
                n_err++;
            end else begin
                want_res = pixel_q.pop_front();
                n_checked++;
                if (got_res.pixel !== want_res.pixel) begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, want_res.pixel, got_res.pixel);
                    n_err++;
                end
                if (got_res.used !== want_res.used) begin
                    $display("%0t: bits_used expected %0d actual %0d",
                             $time, want_res.used, got_res.used);
                    n_err++;
                end
                if (got_res.done !== want_res.done) begin
                    $display("%0t: done_res expected %b actual %b",
                             $time, want_res.done, got_res.done);
                    n_err++;
                end
                if (got_res.status !== want_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_res.status, got_res.status);
                    n_err++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 15) begin
            stall_left = gap_len() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, pixel_q.size());
            $display("** lsb_bit_embedder: FAILED **");
            $finish;
        end
    end

    initial begin
        int             n_rand;
        int             phase_len;
        int             need;
        int             r;
        int             base;
        bit             first_phase;
        lbe_pkg::t_mode new_mode;
        logic [3:0]     new_set;
        logic [23:0]    value;
        lbe_pkg::t_op   op;

        n_err = 0;
        n_sent = 0;
        n_checked = 0;
        n_reg_writes = 0;
        n_done = 0;
        stall_left = 0;
        idle_cycles = 0;
        calm = 1'b0;
        for (int i = 0; i < 4; i++)
            n_status[i] = 0;
        cfg_mode = lbe_pkg::MODE_SINGLE;
        cfg_setting = '0;
        cfg_len = '0;
        msg_buf = '0;
        msg_fill = 0;
        emb_count = '0;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= 1'b0;
        i_data_byte <= '0;
        i_stall     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length after reset: everything passes through as done
        add_checked(lbe_pkg::OP_PIXEL, 8'hA5, mk_res(8'hA5, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_checked(lbe_pkg::OP_PUSH,  8'h00, mk_res(8'h00, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_checked(lbe_pkg::OP_PUSH,  8'hFF, mk_res(8'h00, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_checked(lbe_pkg::OP_PUSH,  8'h12,
                    mk_res(8'h00, 4'd0, 1'b1, lbe_pkg::ST_OVERFLOW));
        add_reg(lbe_pkg::CFG_MESSAGE_BYTES, 24'd2);
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd7);
        add_checked(lbe_pkg::OP_PIXEL, 8'hFF, mk_res(8'h7F, 4'd1, 1'b0, lbe_pkg::ST_OK));
        // out of range settings for both modes
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd8);
        add_checked(lbe_pkg::OP_PIXEL, 8'h3C,
                    mk_res(8'h3C, 4'd0, 1'b0, lbe_pkg::ST_INVALID));
        add_reg(lbe_pkg::CFG_MODE, 24'd1);
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd0);
        add_checked(lbe_pkg::OP_PIXEL, 8'h00,
                    mk_res(8'h00, 4'd0, 1'b0, lbe_pkg::ST_INVALID));
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd9);
        add_checked(lbe_pkg::OP_PIXEL, 8'hFF,
                    mk_res(8'hFF, 4'd0, 1'b0, lbe_pkg::ST_INVALID));
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd15);
        add_checked(lbe_pkg::OP_PIXEL, 8'h81,
                    mk_res(8'h81, 4'd0, 1'b0, lbe_pkg::ST_INVALID));
        // full byte, then a partial final byte
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd8);
        add_item(lbe_pkg::OP_PIXEL, 8'hFF);
        add_item(lbe_pkg::OP_PIXEL, 8'h00);
        add_checked(lbe_pkg::OP_PIXEL, 8'h55, mk_res(8'h55, 4'd0, 1'b1, lbe_pkg::ST_OK));
        // longest message, empty buffer
        add_reg(lbe_pkg::CFG_MESSAGE_BYTES, 24'hFFFFFF);
        add_checked(lbe_pkg::OP_PIXEL, 8'h00,
                    mk_res(8'h00, 4'd0, 1'b0, lbe_pkg::ST_UNDERRUN));
        add_checked(lbe_pkg::OP_PUSH,  8'hC3, mk_res(8'h00, 4'd0, 1'b0, lbe_pkg::ST_OK));
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd1);
        add_item(lbe_pkg::OP_PIXEL, 8'hFE);
        add_reg(lbe_pkg::CFG_MODE, 24'd0);
        add_reg(lbe_pkg::CFG_BIT_SETTING, 24'd0);
        add_item(lbe_pkg::OP_PIXEL, 8'hFF);
        // length cut to zero, push after done, length below what is embedded
        add_reg(lbe_pkg::CFG_MESSAGE_BYTES, 24'd0);
        add_checked(lbe_pkg::OP_PIXEL, 8'h0F, mk_res(8'h0F, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_checked(lbe_pkg::OP_PUSH,  8'hAA, mk_res(8'h00, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_reg(lbe_pkg::CFG_MESSAGE_BYTES, 24'd1);
        add_checked(lbe_pkg::OP_PIXEL, 8'h66, mk_res(8'h66, 4'd0, 1'b1, lbe_pkg::ST_OK));
        add_reg(lbe_pkg::CFG_MESSAGE_BYTES, 24'd3);
        add_item(lbe_pkg::OP_PIXEL, 8'h00);
        add_checked(lbe_pkg::OP_PUSH,  8'h5A,
                    mk_res(8'h00, 4'd0, 1'b0, lbe_pkg::ST_OVERFLOW));

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_reg)
                write_reg(stim_rows[i].idx, stim_rows[i].value);
            else
                send_item(stim_rows[i].op, stim_rows[i].dbyte, stim_rows[i].typed,
                          stim_rows[i].want);
        end

        n_rand = 0;
        first_phase = 1'b1;
        while (n_rand < RANDOM_ITEMS) begin
            drain();
            calm = ($urandom_range(0, 4) == 0);
            new_mode = (first_phase || $urandom_range(0, 3) != 0)
                       ? lbe_pkg::t_mode'($urandom_range(0, 1)) : cfg_mode;
            if ($urandom_range(0, 9) == 0)
                new_set = 4'($urandom_range(0, 15));
            else if (new_mode == lbe_pkg::MODE_SINGLE)
                new_set = 4'($urandom_range(0, 7));
            else
                new_set = 4'($urandom_range(1, 8));
            if (new_mode != cfg_mode || first_phase || $urandom_range(0, 3) == 0) begin
                value = 24'($urandom);
                value[0] = new_mode;
                write_reg(lbe_pkg::CFG_MODE, value);
            end
            if (new_set != cfg_setting || first_phase) begin
                value = 24'($urandom);
                value[3:0] = new_set;
                write_reg(lbe_pkg::CFG_BIT_SETTING, value);
            end
            if (first_phase || $urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 9);
                base = (int'(emb_count) + 7) / 8;
                if (r == 0)
                    value = 24'd0;
                else if (r == 1)
                    value = 24'($urandom_range(0, 24'hFFFFFF));
                else if (r == 2)
                    value = 24'(int'(emb_count) / 8);
                else
                    value = 24'(base + $urandom_range(1, 10));
                write_reg(lbe_pkg::CFG_MESSAGE_BYTES, value);
            end
            first_phase = 1'b0;

            // mostly pushes just ahead of demand, with some noise mixed in
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len; i++) begin
                need = (cfg_mode == lbe_pkg::MODE_SINGLE) ? 1 : int'(cfg_setting);
                r = $urandom_range(0, 99);
                if (r < 12)
                    op = lbe_pkg::t_op'($urandom_range(0, 1));
                else if (msg_fill < need || (msg_fill <= 8 && r < 35))
                    op = lbe_pkg::OP_PUSH;
                else
                    op = lbe_pkg::OP_PIXEL;
                send_item(op, 8'($urandom_range(0, 255)), 1'b0, '0);
                n_rand++;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("sent %0d transactions (%0d random), checked %0d results, %0d register writes",
                 n_sent, n_rand, n_checked, n_reg_writes);
        $display("results seen: ok %0d, overflow %0d, underrun %0d, invalid %0d, done %0d",
                 n_status[lbe_pkg::ST_OK], n_status[lbe_pkg::ST_OVERFLOW],
                 n_status[lbe_pkg::ST_UNDERRUN], n_status[lbe_pkg::ST_INVALID], n_done);
        if (n_err == 0)
            $display("** lsb_bit_embedder: PASSED **");
        else
            $display("** lsb_bit_embedder: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
